### design/s2a_pkg.sv
// Shared types, constants and helpers for the signed radix to ASCII converter.
`default_nettype none

package s2a_pkg;

    localparam int CHAR_W         = 8;
    localparam int ALPHA_CHARS    = 16;
    localparam int ALPHA_W        = CHAR_W * ALPHA_CHARS;
    localparam int SIZE_W         = 5;
    localparam int RADIX_DIGIT_W  = 4;
    localparam int COUNT_W        = 6;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int STEPS_PER_PASS = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

    localparam logic [SIZE_W-1:0] MIN_BASE = 5'd2;

    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0] CH_LOWEST  = 8'd33;
    localparam logic [CHAR_W-1:0] CH_HIGHEST = 8'd127;

    typedef struct packed {
        logic busy;
        logic ok;
    } t_chk_status;

    typedef struct packed {
        logic                     done;
        logic                     zero;
        logic [RADIX_DIGIT_W-1:0] digit;
    } t_div_status;

    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [ALPHA_W-1:0]       alpha,
        input logic [RADIX_DIGIT_W-1:0] idx
    );
        alpha_char = alpha[{idx, 3'b000} +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

### design/s2a_alpha_chk.sv
// Digit alphabet checker: walks the characters once after each config write.
`default_nettype none

module s2a_alpha_chk import s2a_pkg::*; #(
    parameter int MAX_BASE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic [ALPHA_W-1:0] i_alpha,
    output t_chk_status        o_status
);

    localparam int IDX_W = $clog2(MAX_BASE);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_BASE - 1);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_BASE);

    logic             r_busy;
    logic             r_ok;
    logic             r_bad;
    logic [IDX_W-1:0] r_idx;

    logic [CHAR_W-1:0] cur;
    logic              in_use;
    logic              hit;
    logic              size_bad;

    // one character per cycle against every later character in use
    always_comb begin
        cur    = alpha_char(i_alpha, RADIX_DIGIT_W'(r_idx));
        in_use = SIZE_W'(r_idx) < i_size;
        hit    = (cur == CH_PLUS) || (cur == CH_MINUS) ||
                 (cur < CH_LOWEST) || (cur > CH_HIGHEST);
        for (int j = 0; j < ALPHA_CHARS; j++) begin
            if ((SIZE_W'(j) < i_size) && (SIZE_W'(j) > SIZE_W'(r_idx)) &&
                (alpha_char(i_alpha, RADIX_DIGIT_W'(j)) == cur)) begin
                hit = 1'b1;
            end
        end
    end

    // size judged on the final step, once a size write has landed
    assign size_bad = (i_size < MIN_BASE) || (i_size > SIZE_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ok   <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_ok   <= 1'b0;
        end else if (r_busy && (r_idx == LAST_IDX)) begin
            r_busy <= 1'b0;
            r_ok   <= !(r_bad || (in_use && hit) || size_bad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_idx <= '0;
            r_bad <= 1'b0;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            r_bad <= r_bad || (in_use && hit);
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.ok   = r_ok;

endmodule

`default_nettype wire

### design/s2a_div_unit.sv
// Shared divide-by-radix unit: eight restoring steps per pass over the dividend.
`default_nettype none

module s2a_div_unit import s2a_pkg::*; #(
    parameter int PW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_run,
    input  logic [PW-1:0]     i_dividend,
    input  logic [SIZE_W-1:0] i_radix,
    output t_div_status       o_status
);

    localparam int PASSES = PW / STEPS_PER_PASS;
    localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(PASSES - 1);

    logic [PW-1:0]            r_quo;
    logic [RADIX_DIGIT_W-1:0] r_rem;
    logic [PASS_W-1:0]        r_pass;
    logic [PW-1:0]            n_quo_step;
    logic [RADIX_DIGIT_W-1:0] n_rem_step;
    logic                     last_pass;

    // quotient bits shift in as dividend bits shift out of the same register
    always_comb begin
        logic [PW-1:0]            w;
        logic [SIZE_W-1:0]        t;
        logic [RADIX_DIGIT_W-1:0] rm;
        w  = r_quo;
        rm = r_rem;
        for (int k = 0; k < STEPS_PER_PASS; k++) begin
            t = {rm, w[PW-1]};
            w = {w[PW-2:0], 1'b0};
            if (t >= i_radix) begin
                t    = t - i_radix;
                w[0] = 1'b1;
            end
            rm = t[RADIX_DIGIT_W-1:0];
        end
        n_quo_step = w;
        n_rem_step = rm;
    end

    assign last_pass = (r_pass == LAST_PASS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
        end else if (i_load) begin
            r_pass <= '0;
        end else if (i_run) begin
            r_pass <= last_pass ? '0 : r_pass + 1'b1;
        end
    end

    // on the last pass the quotient stays put as the next dividend
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (i_run) begin
            r_quo <= n_quo_step;
            r_rem <= last_pass ? '0 : n_rem_step;
        end
    end

    assign o_status.done  = i_run && last_pass;
    assign o_status.zero  = (n_quo_step == '0);
    assign o_status.digit = n_rem_step;

endmodule

`default_nettype wire

### design/signed_radix_to_ascii_core.sv
// Signed integer to text converter in a configurable radix, top level.
// Usage:
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): index 0 is
//   the alphabet size (radix), 1 and 2 hold digit characters 0..7 and 8..15.
//   After each config beat the alphabet is checked one character at a time; busy
//   is high and o_cfg_ready low during that time.
//   An item is taken on a clock edge with start high and busy low. busy stays
//   high until the last character of that item is out; an error beat leaves it low.
//   Results come out one per cycle on o_valid with o_character, o_last,
//   o_base_error and o_char_count (count only on the last beat). The receiver
//   has no way to hold them off.
//   Sequence: each digit is worked out in passes of the shared divide unit,
//   least significant first; a stack read-out state then also puts out the
//   minus sign, and the digits follow back to back from the top of the stack.
//   A bad alphabet gives a single error beat in the cycle after start.
//   Reset clears all config registers, so the alphabet reads as invalid until
//   written; the digit stack needs no clearing.
`default_nettype none

module signed_radix_to_ascii_core import s2a_pkg::*; #(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_BITS-1:0]  i_value,
    output logic                   o_valid,
    output logic [CHAR_W-1:0]      o_character,
    output logic                   o_last,
    output logic                   o_base_error,
    output logic [COUNT_W-1:0]     o_char_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DIGIT_W = $clog2(MAX_BASE);
    localparam int PTR_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W   = $clog2(VALUE_BITS + 2);
    localparam int PW      = ((VALUE_BITS + STEPS_PER_PASS - 1) / STEPS_PER_PASS) *
                             STEPS_PER_PASS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    // config registers
    logic [SIZE_W-1:0]     r_base_size;
    logic [CFG_DATA_W-1:0] r_digits_low;
    logic [CFG_DATA_W-1:0] r_digits_high;
    logic [ALPHA_W-1:0]    alpha;
    logic                  cfg_we;

    t_chk_status chk_st;
    t_div_status div_st;

    logic                  accept;
    logic [VALUE_BITS-1:0] mag;
    logic                  div_load;
    logic                  div_run;

    // digit stack
    logic [DIGIT_W-1:0] r_stack [VALUE_BITS];
    logic [DIGIT_W-1:0] r_rd_data;

    t_state             r_state, n_state;
    logic               r_neg, n_neg;
    logic [CNT_W-1:0]   r_dcnt, n_dcnt;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_emit, n_emit;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic               r_valid, n_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic               r_err, n_err;
    logic [COUNT_W-1:0] r_count, n_count;

    assign alpha       = {r_digits_high, r_digits_low};
    assign o_cfg_ready = !chk_st.busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size   <= '0;
            r_digits_low  <= '0;
            r_digits_high <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_SIZE:   r_base_size   <= i_cfg_data[SIZE_W-1:0];
                CFG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                CFG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    s2a_alpha_chk #(
        .MAX_BASE (MAX_BASE)
    ) u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (cfg_we),
        .i_size   (r_base_size),
        .i_alpha  (alpha),
        .o_status (chk_st)
    );

    assign busy     = (r_state != ST_IDLE) || chk_st.busy;
    assign accept   = start && !busy;
    assign mag      = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
    assign div_load = accept && chk_st.ok;
    assign div_run  = (r_state == ST_DIV);

    s2a_div_unit #(
        .PW (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_run      (div_run),
        .i_dividend (PW'(mag)),
        .i_radix    (r_base_size),
        .o_status   (div_st)
    );

    // digits pushed least significant first, popped from the top
    always_ff @(posedge i_clk) begin
        if (div_st.done) begin
            r_stack[r_dcnt[PTR_W-1:0]] <= div_st.digit[DIGIT_W-1:0];
        end
        r_rd_data <= r_stack[r_ptr];
    end

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_dcnt  = r_dcnt;
        n_total = r_total;
        n_emit  = r_emit;
        n_ptr   = r_ptr;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        n_err   = r_err;
        n_count = r_count;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!chk_st.ok) begin
                        n_valid = 1'b1;
                        n_char  = '0;
                        n_last  = 1'b1;
                        n_err   = 1'b1;
                        n_count = '0;
                    end else begin
                        n_state = ST_DIV;
                        n_neg   = i_value[VALUE_BITS-1];
                        n_dcnt  = '0;
                        n_emit  = '0;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    n_dcnt = r_dcnt + 1'b1;
                    if (div_st.zero) begin
                        n_state = ST_SIGN;
                        n_ptr   = r_dcnt[PTR_W-1:0];
                        n_total = r_dcnt + 1'b1 + CNT_W'(r_neg);
                    end
                end
            end
            ST_SIGN: begin
                // stack read of the top digit goes out on this edge
                n_ptr   = r_ptr - 1'b1;
                n_state = ST_EMIT;
                if (r_neg) begin
                    n_emit  = r_emit + 1'b1;
                    n_valid = 1'b1;
                    n_char  = CH_MINUS;
                    n_err   = 1'b0;
                    n_last  = (n_emit == r_total);
                    n_count = n_last ? COUNT_W'(r_total) : '0;
                end
            end
            ST_EMIT: begin
                n_ptr   = r_ptr - 1'b1;
                n_emit  = r_emit + 1'b1;
                n_valid = 1'b1;
                n_char  = alpha_char(alpha, RADIX_DIGIT_W'(r_rd_data));
                n_err   = 1'b0;
                n_last  = (n_emit == r_total);
                n_count = n_last ? COUNT_W'(r_total) : '0;
                if (n_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_dcnt  <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_dcnt  <= n_dcnt;
            r_emit  <= n_emit;
        end
        r_neg   <= n_neg;
        r_total <= n_total;
        r_ptr   <= n_ptr;
        r_char  <= n_char;
        r_last  <= n_last;
        r_err   <= n_err;
        r_count <= n_count;
    end

    assign o_valid      = r_valid;
    assign o_character  = r_char;
    assign o_last       = r_last;
    assign o_base_error = r_err;
    assign o_char_count = r_count;

    // characters of one item leave back to back
    a_run_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("gap inside a character run");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("block idle with characters outstanding");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_base_error |-> o_last && (o_char_count == '0))
        else $error("error beat not a lone last beat with zero count");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_valid || o_base_error)
        else $error("character beat straight after accepting an item");

    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !o_base_error |-> (o_char_count != '0))
        else $error("last beat of a conversion carries zero count");

endmodule

`default_nettype wire
